// File: hdl/fct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_pkg
// Shared constants, types and codes of the frustum culling test block.
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int PLANE_COUNT      = 6;
    localparam int NORMAL_W         = 12;
    localparam int OFFSET_W         = 28;
    localparam int CFG_DATA_W       = 64;
    localparam int CFG_ADDR_W       = 3;
    localparam int COORD_WIDTH_DEF  = 24;
    localparam int NORMAL_FRAC_DEF  = 10;

    // plane register bit positions
    localparam int NX_LSB  = 0;
    localparam int NY_LSB  = 12;
    localparam int NZ_LSB  = 24;
    localparam int OFF_LSB = 36;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_POINT  = 2'd0;
    localparam opcode_t OP_SPHERE = 2'd1;
    localparam opcode_t OP_BOX    = 2'd2;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] nx;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nz;
        logic signed [OFFSET_W-1:0] d;
    } plane_t;

    // load strobes of the three lane stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } lane_ctrl_t;

endpackage

// File: hdl/fct_plane_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_plane_regs
// Six plane registers written through the configuration port, decoded into
// normal components and offset.
// ----------------------------------------------------------------------------
module fct_plane_regs import fct_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output plane_t                planes [PLANE_COUNT]
);

    logic [CFG_DATA_W-1:0] plane_reg [PLANE_COUNT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PLANE_COUNT; i++) begin
                plane_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            // drop writes beyond the last plane
            for (int i = 0; i < PLANE_COUNT; i++) begin
                if (cfg_addr == CFG_ADDR_W'(i)) begin
                    plane_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            planes[i].nx = plane_reg[i][NX_LSB +: NORMAL_W];
            planes[i].ny = plane_reg[i][NY_LSB +: NORMAL_W];
            planes[i].nz = plane_reg[i][NZ_LSB +: NORMAL_W];
            planes[i].d  = plane_reg[i][OFF_LSB +: OFFSET_W];
        end
    end

endmodule

// File: hdl/fct_plane_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fct_plane_lane
// Three-stage test of one item against one plane: vertex select and offset,
// three products, exact sum and sign.
// ----------------------------------------------------------------------------
module fct_plane_lane import fct_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic                          aclk,
    input  lane_ctrl_t                    ctrl,
    input  plane_t                        plane,
    input  logic                          is_box,
    input  logic                          is_sphere,
    input  logic signed [COORD_WIDTH-1:0] lo_x,
    input  logic signed [COORD_WIDTH-1:0] lo_y,
    input  logic signed [COORD_WIDTH-1:0] lo_z,
    input  logic signed [COORD_WIDTH-1:0] hi_x,
    input  logic signed [COORD_WIDTH-1:0] hi_y,
    input  logic signed [COORD_WIDTH-1:0] hi_z,
    input  logic        [COORD_WIDTH-2:0] radius,
    output logic                          neg
);

    localparam int PROD_W = NORMAL_W + COORD_WIDTH;
    localparam int OFF_W  = ((OFFSET_W > COORD_WIDTH) ? OFFSET_W : COORD_WIDTH) + 1;
    localparam int SUM_A  = PROD_W + 2;
    localparam int SUM_B  = OFF_W + NORMAL_FRAC_BITS;
    localparam int SUM_W  = ((SUM_A > SUM_B) ? SUM_A : SUM_B) + 1;

    // stage 1: positive vertex and offset term
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg, pz_reg;
    logic signed [COORD_WIDTH-1:0] px_next, py_next, pz_next;
    logic signed [OFF_W-1:0]       off1_reg, off1_next;
    // stage 2: products
    logic signed [PROD_W-1:0]      prx_reg, pry_reg, prz_reg;
    logic signed [PROD_W-1:0]      prx_next, pry_next, prz_next;
    logic signed [OFF_W-1:0]       off2_reg;
    // stage 3: sign of the plane value
    logic signed [SUM_W-1:0]       sum_next;
    logic                          neg_reg;

    always_comb begin
        // box takes the max corner where the normal component is not negative
        px_next = (is_box && !plane.nx[NORMAL_W-1]) ? hi_x : lo_x;
        py_next = (is_box && !plane.ny[NORMAL_W-1]) ? hi_y : lo_y;
        pz_next = (is_box && !plane.nz[NORMAL_W-1]) ? hi_z : lo_z;
        off1_next = OFF_W'(plane.d)
                  + (is_sphere ? OFF_W'($signed({1'b0, radius})) : OFF_W'(0));
    end

    always_comb begin
        prx_next = PROD_W'(plane.nx) * PROD_W'(px_reg);
        pry_next = PROD_W'(plane.ny) * PROD_W'(py_reg);
        prz_next = PROD_W'(plane.nz) * PROD_W'(pz_reg);
    end

    always_comb begin
        sum_next = SUM_W'(prx_reg) + SUM_W'(pry_reg) + SUM_W'(prz_reg)
                 + (SUM_W'(off2_reg) <<< NORMAL_FRAC_BITS);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            pz_reg   <= pz_next;
            off1_reg <= off1_next;
        end
        if (ctrl.ld2) begin
            prx_reg  <= prx_next;
            pry_reg  <= pry_next;
            prz_reg  <= prz_next;
            off2_reg <= off1_reg;
        end
        if (ctrl.ld3) begin
            neg_reg <= sum_next[SUM_W-1];
        end
    end

    assign neg = neg_reg;

endmodule

// File: hdl/frustum_cull_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_cull_test
// Point, sphere or axis-aligned box test against six frustum planes.
// Pipeline: input register, three plane stages and output register, in that
//   order from the input transfer to m_tvalid.
// Throughput: one item per cycle; each stage holds only while its successor
//   is full and stalled.
// Reset: synchronous, clears all valid bits and the plane registers to zero,
//   after which every object tests inside.
// ----------------------------------------------------------------------------
module frustum_cull_test import fct_pkg::*; #(
    parameter int COORD_WIDTH      = COORD_WIDTH_DEF,
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // opcode, corner_lo_x/y/z, corner_hi_x/y/z, sphere_radius, zero pad
    input  logic [((7*COORD_WIDTH+1+7)/8)*8-1:0] s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // inside_res, zero pad
    output logic [7:0]            m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int LO_X  = 2;
    localparam int LO_Y  = LO_X + CW;
    localparam int LO_Z  = LO_Y + CW;
    localparam int HI_X  = LO_Z + CW;
    localparam int HI_Y  = HI_X + CW;
    localparam int HI_Z  = HI_Y + CW;
    localparam int RAD   = HI_Z + CW;

    plane_t     planes [PLANE_COUNT];
    lane_ctrl_t ctrl;
    logic [PLANE_COUNT-1:0] neg;

    opcode_t               op_in;
    logic                  box_reg, sphere_reg;
    logic signed [CW-1:0]  lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [CW-1:0]  hi_x_reg, hi_y_reg, hi_z_reg;
    logic        [CW-2:0]  radius_reg;
    logic                  inside_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    fct_plane_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .planes    (planes)
    );

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        rdy4     = !v4_reg || m_tready;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        rdy1     = !v1_reg || rdy2;
        rdy0     = !v0_reg || rdy1;
        ctrl.ld1 = rdy1;
        ctrl.ld2 = rdy2;
        ctrl.ld3 = rdy3;
    end

    assign s_tready = rdy0;
    assign op_in    = s_tdata[1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy0) begin
                v0_reg <= s_tvalid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0) begin
            // the unused fourth code falls on the box path
            box_reg    <= op_in[1];
            sphere_reg <= (op_in == OP_SPHERE);
            lo_x_reg   <= s_tdata[LO_X +: CW];
            lo_y_reg   <= s_tdata[LO_Y +: CW];
            lo_z_reg   <= s_tdata[LO_Z +: CW];
            hi_x_reg   <= s_tdata[HI_X +: CW];
            hi_y_reg   <= s_tdata[HI_Y +: CW];
            hi_z_reg   <= s_tdata[HI_Z +: CW];
            radius_reg <= s_tdata[RAD +: CW-1];
        end
        if (rdy4) begin
            inside_reg <= ~|neg;
        end
    end

    for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_lane
        fct_plane_lane #(
            .COORD_WIDTH      (COORD_WIDTH),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .plane     (planes[i]),
            .is_box    (box_reg),
            .is_sphere (sphere_reg),
            .lo_x      (lo_x_reg),
            .lo_y      (lo_y_reg),
            .lo_z      (lo_z_reg),
            .hi_x      (hi_x_reg),
            .hi_y      (hi_y_reg),
            .hi_z      (hi_z_reg),
            .radius    (radius_reg),
            .neg       (neg[i])
        );
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {7'b0, inside_reg};

endmodule
